>>> sv/tdp_pkg.sv
`default_nettype none
package tdp_pkg;

  localparam int unsigned ItemWidth = 32;

  typedef struct packed {
    logic signed [ItemWidth-1:0] value;
    logic                        last;
  } req_item_t;

  typedef struct packed {
    logic signed [ItemWidth-1:0] value_out;
    logic                        is_prime;
    logic                        last_out;
  } rsp_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } seq_state_t;

  // sequencer -> divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

  // divider -> sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

>>> sv/tdp_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
module tdp_div #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned DIV_WIDTH  = 17
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire tdp_pkg::div_ctl_t      ctl,
  input  wire logic [DATA_WIDTH-1:0]  dividend,
  input  wire logic [DIV_WIDTH-1:0]   divisor,
  output tdp_pkg::div_status_t        status,
  output logic      [DIV_WIDTH-1:0]   remainder
);

  localparam int unsigned CntWidth = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] shreg;
  logic [DIV_WIDTH-1:0]  dvs;
  logic [DIV_WIDTH-1:0]  rem;
  logic [CntWidth-1:0]   cnt;
  logic                  busy;
  logic                  done;
  logic [DIV_WIDTH:0]    trial;
  logic [DIV_WIDTH:0]    diff;

  assign trial = {rem, shreg[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CntWidth'(DATA_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[DATA_WIDTH-2:0], 1'b0};
      if (!diff[DIV_WIDTH]) begin
        rem <= diff[DIV_WIDTH-1:0];
      end else begin
        rem <= trial[DIV_WIDTH-1:0];
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign remainder   = rem;

endmodule
`default_nettype wire

>>> sv/trial_division_prime_tester_core.sv
// Magnitudes 0 to 3 go from accept to result with no division; otherwise trial divisors
//   2, 3, ... are tried on the divider until one divides or its square exceeds the magnitude.
// One item at a time: no new item is taken until the result is loaded; the next can be
//   taken in the cycle after that, as every trial division uses the one bit-serial divider.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst, synchronous, active high) empties the output and returns to idle.
`default_nettype none
module trial_division_prime_tester_core #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire tdp_pkg::req_item_t req_item,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output tdp_pkg::rsp_item_t      rsp_item
);

  // divisor never exceeds sqrt(2^(W-1)) + 1
  localparam int unsigned DivWidth = DATA_WIDTH / 2 + 1;
  // running square of the divisor
  localparam int unsigned SqWidth  = 2 * DivWidth;

  tdp_pkg::seq_state_t   state, state_next;
  tdp_pkg::div_ctl_t     div_ctl;
  tdp_pkg::div_status_t  div_status;
  logic [DivWidth-1:0]   div_rem;

  // working registers
  logic [DATA_WIDTH-1:0] magnitude, magnitude_next;
  logic [DivWidth-1:0]   trial_divisor, trial_divisor_next;
  logic [SqWidth-1:0]    square, square_next;
  logic                  prime, prime_next;
  tdp_pkg::req_item_t    held_item, held_item_next;

  // output register
  logic                  rsp_valid_next;
  tdp_pkg::rsp_item_t    rsp_reg, rsp_reg_next;

  // magnitude of the low DATA_WIDTH bits, read as signed
  logic [DATA_WIDTH-1:0] raw;
  logic [DATA_WIDTH-1:0] raw_neg;
  logic [DATA_WIDTH-1:0] mag_in;

  assign raw     = req_item.value[DATA_WIDTH-1:0];
  assign raw_neg = ~raw + {{(DATA_WIDTH-1){1'b0}}, 1'b1};
  assign mag_in  = raw[DATA_WIDTH-1] ? raw_neg : raw;

  logic sq_over;
  assign sq_over = square > {{(SqWidth-DATA_WIDTH){1'b0}}, magnitude};

  tdp_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .DIV_WIDTH  (DivWidth)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (div_ctl),
    .dividend  (magnitude),
    .divisor   (trial_divisor),
    .status    (div_status),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tdp_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    magnitude     <= magnitude_next;
    trial_divisor <= trial_divisor_next;
    square        <= square_next;
    prime         <= prime_next;
    held_item     <= held_item_next;
    rsp_reg       <= rsp_reg_next;
  end

  always_comb begin
    state_next         = state;
    magnitude_next     = magnitude;
    trial_divisor_next = trial_divisor;
    square_next        = square;
    prime_next         = prime;
    held_item_next     = held_item;
    rsp_reg_next       = rsp_reg;
    rsp_valid_next     = rsp_valid && !rsp_ready;
    req_ready          = 1'b0;
    div_ctl.start      = 1'b0;

    unique case (state)
      tdp_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          held_item_next     = req_item;
          magnitude_next     = mag_in;
          trial_divisor_next = DivWidth'(2);
          square_next        = SqWidth'(4);
          // 0 and 1 are not prime
          prime_next         = mag_in > DATA_WIDTH'(1);
          state_next         = tdp_pkg::ST_CHECK;
        end
      end
      tdp_pkg::ST_CHECK: begin
        // inclusive bound: keep going while d*d <= magnitude
        if (!prime || sq_over) begin
          state_next = tdp_pkg::ST_DONE;
        end else begin
          div_ctl.start = 1'b1;
          state_next    = tdp_pkg::ST_DIV;
        end
      end
      tdp_pkg::ST_DIV: begin
        if (div_status.done) begin
          if (div_rem == '0) begin
            prime_next = 1'b0;
          end
          trial_divisor_next = trial_divisor + 1'b1;
          // (d+1)^2 = d^2 + 2d + 1
          square_next = square + {{(SqWidth-DivWidth-1){1'b0}}, trial_divisor, 1'b1};
          state_next  = tdp_pkg::ST_CHECK;
        end
      end
      tdp_pkg::ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_reg_next.value_out = held_item.value;
          rsp_reg_next.is_prime  = prime;
          rsp_reg_next.last_out  = held_item.last;
          rsp_valid_next         = 1'b1;
          state_next             = tdp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tdp_pkg::ST_IDLE;
      end
    endcase
  end

  assign rsp_item = rsp_reg;

endmodule
`default_nettype wire

>>> sv/tdp_checker.sv
`default_nettype none
module tdp_checker #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire tdp_pkg::rsp_item_t rsp_item
);

  logic [DATA_WIDTH-1:0] low;
  assign low = rsp_item.value_out[DATA_WIDTH-1:0];

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
    else $error("result changed while stalled");

  // one item in flight: ready drops once an item is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("input ready right after an accept");

  // an even magnitude other than two is never prime
  a_even: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.is_prime |->
      low[0] || low == {{(DATA_WIDTH-2){1'b0}}, 2'b10} ||
      low == {{(DATA_WIDTH-2){1'b1}}, 2'b10})
    else $error("even value flagged prime");

  // reset leaves an empty output and an idle input side
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("bad state after reset");

endmodule

bind trial_division_prime_tester_core tdp_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_tdp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_item  (rsp_item)
);
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // Receiver hold-off used by the back-pressure test, in clock cycles.
  localparam int unsigned LongStall  = 400;
  // Quiet cycles after the last result, so a stray result still gets caught.
  localparam int unsigned TailCycles = 64;
  // Chance, in percent, that either side idles in a given cycle.
  localparam int unsigned IdlePct    = 19;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  tdp_pkg::req_item_t req_item = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  tdp_pkg::rsp_item_t rsp_item;

  // Verdicts still owed by the block, oldest first.
  tdp_pkg::rsp_item_t pending_verdicts[$];
  int unsigned        fail_count = 0;

  // While set, neither side idles: gives a stretch of full-rate traffic.
  bit          calm = 1'b0;

  // Long receiver hold-offs: the test bumps the request count, the receiver
  // serves each request and counts the stall down on its own.
  int unsigned stall_requests = 0;
  int unsigned stall_served   = 0;
  int unsigned stall_left     = 0;

  trial_division_prime_tester_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_item (req_item),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_item (rsp_item)
  );

  always #5 clk = ~clk;

  // Expected verdict for one number: magnitude of the signed value, then
  // trial division by 2, 3, ... while d*d <= magnitude. Zero and one are
  // not prime; the inclusive bound makes perfect squares composite; the most
  // negative value has magnitude 2^31 and is therefore even.
  function automatic tdp_pkg::rsp_item_t prime_verdict(input tdp_pkg::req_item_t num);
    tdp_pkg::rsp_item_t verdict;
    logic [31:0]        mag;
    longint unsigned    m;
    longint unsigned    d;
    bit                 prime;
    mag   = num.value[31] ? -num.value : num.value;
    m     = mag;
    prime = (m >= 2);
    for (d = 2; prime && d * d <= m; d++) begin
      if (m % d == 0) prime = 1'b0;
    end
    verdict.value_out = num.value;
    verdict.is_prime  = prime;
    verdict.last_out  = num.last;
    return verdict;
  endfunction

  // Random number to test. Slow cases are kept short: big odd primes would
  // run trial division up to their square root, so large values are either even or the
  // product of a small odd factor and a random cofactor.
  function automatic logic signed [31:0] pick_number();
    int unsigned sel;
    int unsigned p;
    int unsigned q;
    logic [31:0] v;
    sel = $urandom_range(99);
    if (sel < 50) begin
      v = $urandom_range(4095);
    end else if (sel < 70) begin
      v = $urandom_range(65535);
    end else if (sel < 85) begin
      v = $urandom() & ~32'd1;
    end else begin
      p = 2 * $urandom_range(15, 1) + 1;
      q = $urandom_range(32'h7FFF_FFFF / p);
      v = p * q;
    end
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  // Offer one number and hold it until the block takes it. Called at a
  // rising edge; returns at the edge where the item was accepted.
  task automatic send_number(input logic signed [31:0] v, input logic lst);
    while (!calm && $urandom_range(99) < IdlePct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid      <= 1'b1;
    req_item.value <= v;
    req_item.last  <= lst;
    do @(posedge clk); while (!req_ready);
    pending_verdicts.push_back(prime_verdict('{value: v, last: lst}));
  endtask

  // Drop valid and wait for every owed verdict to come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  // Edge values of the field, tiny magnitudes, perfect squares, small and
  // moderate primes, a product of two close primes, and the most negative.
  task automatic test_directed();
    logic signed [31:0] nums[$];
    int                 i;
    nums = '{0, 1, -1, 2, -2, 3, -3, 4, -4, 9, -25, 49, 121, 169, 7, 97, -97,
             10403, 65521, 2147483646, 2147483645, -2147483645,
             32'sh8000_0000};
    for (i = 0; i < nums.size(); i++) begin
      send_number(nums[i], (i % 4 == 3) || (i == nums.size() - 1));
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the result register fills and the block stops taking items.
  // Small values keep each test short, well inside the hold-off.
  task automatic test_back_pressure();
    int i;
    stall_requests++;
    for (i = 0; i < 8; i++) send_number($urandom_range(30), i == 7);
  endtask

  // Sender pauses until nothing is owed, then carries on.
  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 4; i++) send_number(pick_number(), 1'b0);
    wait_drained();
    for (i = 0; i < 4; i++) send_number(pick_number(), i == 3);
  endtask

  // Random numbers with random last marks; the first stretch runs with no
  // idling on either side, the rest with random gaps.
  task automatic test_random(input int unsigned count);
    int unsigned i;
    calm = 1'b1;
    for (i = 0; i < count; i++) begin
      if (i == count / 4) calm = 1'b0;
      send_number(pick_number(), $urandom_range(1));
    end
  endtask

  // Receiver: random ready, except during a requested long hold-off.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_served != stall_requests) begin
      rsp_ready    <= 1'b0;
      stall_served <= stall_served + 1;
      stall_left   <= LongStall;
    end else begin
      rsp_ready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // Result check: each accepted item against the oldest owed verdict.
  always @(posedge clk) begin
    tdp_pkg::rsp_item_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_ready) begin
      if (pending_verdicts.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: value %0d prime %0b last %0b",
                   rsp_item.value_out, rsp_item.is_prime, rsp_item.last_out);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (rsp_item.value_out !== want.value_out || rsp_item.is_prime !== want.is_prime ||
            rsp_item.last_out !== want.last_out) begin
          if (fail_count < 10)
            $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     want.value_out, want.is_prime, want.last_out,
                     rsp_item.value_out, rsp_item.is_prime, rsp_item.last_out);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_back_pressure();
    test_drain_pause();
    test_random(60);
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest correct run.
  initial begin
    #50_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
